// File: design/tcce_pkg.sv
// Shared types and constants of the text console cursor engine.
// No dependencies; the top module and the bench import it.
package tcce_pkg;

    localparam int COLS_DEF     = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STEP_DEF = 8;

    localparam logic [15:0] BLANK_CELL = 16'h0F20;
    localparam logic [7:0]  ATTR_RST   = 8'h0F;

    // Byte codes with a meaning of their own
    localparam logic [7:0] CH_BS     = 8'd8;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_FF     = 8'd12;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_PR_LO  = 8'd32;
    localparam logic [7:0] CH_PR_HI  = 8'd126;

    // Command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDATA,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_FINISH
    } t_state;

endpackage

// File: design/tcce_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/text_console_cursor_engine_top.sv
// Text console cursor engine: takes bytes and read commands, keeps the cursor
// row and column and a ROWS x COLS cell store (16-bit cells, attribute in the
// high byte) in one RAM. Depends on tcce_pkg and tcce_ram.
//
// One item is worked at a time; o_stall is high while an item is in work.
// A read command goes through accept, RAM read, capture and result. A
// printable or control byte goes through accept, update and result. A
// newline, a tab past the last stop or a column wrap on the bottom row
// scrolls: the store is copied one cell per cycle through the single write
// port. Form feed walks the whole store with blanks. After reset a clearing
// pass over all COLS*ROWS cells (2000 at the default size) blanks the store
// before the first item is taken; attribute writes are taken during it. The
// result sits in an output register, so the next item is accepted while it
// waits.
module text_console_cursor_engine_top
    import tcce_pkg::*;
#(
    parameter int COLS     = COLS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STEP = TAB_STEP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    // result item channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic [10:0] o_cursor_pos,
    output logic [15:0] o_cell_data,
    // attribute register
    input  logic        i_attr_we,
    input  logic [7:0]  i_attr_data
);

    localparam int NCELLS = COLS * ROWS;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int PH_W   = $clog2(TAB_STEP);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(NCELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(NCELLS - COLS);
    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLS);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [PH_W-1:0]   LAST_PH    = PH_W'(TAB_STEP - 1);

    // Control state
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [PH_W-1:0]   r_ph, n_ph;      // column modulo TAB_STEP
    logic [7:0]        r_attr;
    logic              r_ovalid, n_ovalid;
    logic              r_boot, n_boot;  // clearing pass after reset, no item

    // Item payload and result payload
    logic              r_cmd, n_cmd;
    logic [7:0]        r_char, n_char;
    logic [10:0]       r_idx, n_idx;
    logic [15:0]       r_data, n_data;
    logic [4:0]        r_orow, n_orow;
    logic [6:0]        r_ocol, n_ocol;
    logic [10:0]       r_opos, n_opos;
    logic [15:0]       r_odata, n_odata;

    // RAM port
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_wdata, ram_rdata;

    // Cursor arithmetic
    logic [15:0]       pos_wide;
    logic [15:0]       idx_wide;
    logic [COL_W:0]    col_inc;
    logic [COL_W+4:0]  tab_col;
    logic              printable;
    logic              out_free;

    assign pos_wide  = 16'(r_row) * 16'(COLS) + 16'(r_col);
    assign idx_wide  = 16'(r_idx);
    assign col_inc   = (COL_W+1)'(r_col) + (COL_W+1)'(1);
    assign tab_col   = (COL_W+5)'(r_col) + (COL_W+5)'(TAB_STEP) - (COL_W+5)'(r_ph);
    assign printable = (r_char >= CH_PR_LO) && (r_char <= CH_PR_HI);
    assign out_free  = !r_ovalid || !i_stall;

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_ovalid;
    assign o_cursor_row = r_orow;
    assign o_cursor_col = r_ocol;
    assign o_cursor_pos = r_opos;
    assign o_cell_data  = r_odata;

    tcce_ram #(
        .WIDTH (16),
        .DEPTH (NCELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;   // blank the store before the first item
            r_k      <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_ph     <= '0;
            r_attr   <= ATTR_RST;
            r_ovalid <= 1'b0;
            r_boot   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_row    <= n_row;
            r_col    <= n_col;
            r_ph     <= n_ph;
            r_ovalid <= n_ovalid;
            r_boot   <= n_boot;
            if (i_attr_we) begin
                r_attr <= i_attr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_char  <= n_char;
        r_idx   <= n_idx;
        r_data  <= n_data;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_opos  <= n_opos;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_row     = r_row;
        n_col     = r_col;
        n_ph      = r_ph;
        n_boot    = r_boot;
        n_cmd     = r_cmd;
        n_char    = r_char;
        n_idx     = r_idx;
        n_data    = r_data;
        n_orow    = r_orow;
        n_ocol    = r_ocol;
        n_opos    = r_opos;
        n_odata   = r_odata;
        n_ovalid  = r_ovalid && i_stall;   // drop the result once taken
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = BLANK_CELL;
        ram_re    = 1'b0;
        ram_raddr = r_k + COLS_A;

        unique case (r_state)
            ST_IDLE: begin
                // take the item and latch its fields
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_char  = i_char_code;
                    n_idx   = i_cell_index;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (r_cmd == CMD_READ) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_wide[ADDR_W-1:0];
                    n_state   = ST_RDATA;
                end else if (printable) begin
                    // store the cell, advance the column, wrap at the right edge
                    ram_we    = 1'b1;
                    ram_waddr = pos_wide[ADDR_W-1:0];
                    ram_wdata = {r_attr, r_char};
                    n_state   = ST_FINISH;
                    n_ph      = (r_ph == LAST_PH) ? '0 : r_ph + PH_W'(1);
                    n_col     = col_inc[COL_W-1:0];
                    if (col_inc == (COL_W+1)'(COLS)) begin
                        n_col = '0;
                        n_ph  = '0;
                        if (r_row != LAST_ROW) begin
                            n_row = r_row + ROW_W'(1);
                        end else begin
                            n_k     = '0;
                            n_state = ST_SCROLL;
                        end
                    end
                end else begin
                    n_state = ST_FINISH;
                    unique case (r_char) inside
                        CH_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - COL_W'(1);
                                n_ph  = (r_ph == '0) ? LAST_PH : r_ph - PH_W'(1);
                            end
                        end
                        CH_TAB, CH_LF: begin
                            if ((r_char == CH_TAB) && (tab_col < (COL_W+5)'(COLS))) begin
                                n_col = tab_col[COL_W-1:0];
                                n_ph  = '0;
                            end else begin
                                // next line, scroll on the bottom row
                                n_col = '0;
                                n_ph  = '0;
                                if (r_row != LAST_ROW) begin
                                    n_row = r_row + ROW_W'(1);
                                end else begin
                                    n_k     = '0;
                                    n_state = ST_SCROLL;
                                end
                            end
                        end
                        CH_FF: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_ph    = '0;
                            n_k     = '0;
                            n_state = ST_CLEAR;
                        end
                        CH_CR: begin
                            n_col = '0;
                            n_ph  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_RDATA: begin
                n_data  = (idx_wide < 16'(NCELLS)) ? ram_rdata : 16'h0000;
                n_state = ST_FINISH;
            end

            ST_SCROLL: begin
                // read cell k+COLS while the cell read last cycle lands at k-1
                ram_re    = (r_k != SCROLL_END);
                ram_raddr = r_k + COLS_A;
                ram_we    = (r_k != '0);
                ram_waddr = r_k - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (r_k == SCROLL_END) begin
                    n_state = ST_BLANK;
                end else begin
                    n_k = r_k + ADDR_W'(1);
                end
            end

            ST_BLANK: begin
                // blank the bottom row
                ram_we = 1'b1;
                n_k    = r_k + ADDR_W'(1);
                if (r_k == LAST_CELL) begin
                    n_state = ST_FINISH;
                end
            end

            ST_CLEAR: begin
                // blank the whole store; after reset no item is pending
                ram_we = 1'b1;
                n_k    = r_k + ADDR_W'(1);
                if (r_k == LAST_CELL) begin
                    n_state = r_boot ? ST_IDLE : ST_FINISH;
                    n_boot  = 1'b0;
                end
            end

            ST_FINISH: begin
                // hand the result to the output register once it is free
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_orow   = 5'(8'(r_row));
                    n_ocol   = 7'(8'(r_col));
                    n_opos   = pos_wide[10:0];
                    n_odata  = (r_cmd == CMD_READ) ? r_data : 16'h0000;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: bench/testbench.sv
// Self-checking bench for text_console_cursor_engine_top: a shadow copy of the
// console (cursor and cell store) predicts every result. Depends on tcce_pkg
// and the top. Drives both channels with random idling, checks results in order.
module testbench;
    import tcce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS         = COLS_DEF;
    localparam int ROWS         = ROWS_DEF;
    localparam int TAB_STEP     = TAB_STEP_DEF;
    localparam int NCELLS       = COLS * ROWS;
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;       // watch for stray results at the end
    localparam longint TIMEOUT_NS = 64'd50_000_000;

    // One result item as the block reports it
    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [10:0] pos;
        logic [15:0] data;
    } t_cursor_result;

    // Shadow of the console: cursor, cell store and attribute register.
    // note_item advances it for each accepted input item and queues the
    // cursor that the block must report; check_result compares against it.
    class t_console_shadow;
        logic [15:0]    cells [NCELLS];
        logic [4:0]     row;
        logic [6:0]     col;
        logic [7:0]     attr;
        t_cursor_result pending_cursors [$];
        int unsigned    n_errors;
        int unsigned    n_items;
        int unsigned    n_checked;
        int unsigned    n_reads;
        int unsigned    n_scrolls;
        int unsigned    n_clears;
        int unsigned    n_wraps;

        function new();
            foreach (cells[i]) cells[i] = BLANK_CELL;
            row = '0;
            col = '0;
            attr = ATTR_RST;
        endfunction

        function void scroll_store();
            for (int i = 0; i < NCELLS - COLS; i++) cells[i] = cells[i + COLS];
            for (int i = NCELLS - COLS; i < NCELLS; i++) cells[i] = BLANK_CELL;
            n_scrolls++;
        endfunction

        function void line_feed();
            col = '0;
            if (row < ROWS - 1) row = row + 1'b1;
            else scroll_store();
        endfunction

        function void note_item(logic cmd, logic [7:0] ch, logic [10:0] idx);
            t_cursor_result r;
            int nxt;
            r.data = '0;
            n_items++;
            if (cmd == CMD_CHAR) begin
                if (ch >= CH_PR_LO && ch <= CH_PR_HI) begin
                    cells[int'(row) * COLS + int'(col)] = {attr, ch};
                    col = col + 1'b1;
                    if (col >= COLS) begin
                        n_wraps++;
                        line_feed();
                    end
                end else begin
                    case (ch)
                        CH_BS: begin
                            if (col > 0) col = col - 1'b1;
                        end
                        CH_TAB: begin
                            nxt = (int'(col) / TAB_STEP + 1) * TAB_STEP;
                            if (nxt < COLS) col = nxt[6:0];
                            else line_feed();
                        end
                        CH_LF: begin
                            line_feed();
                        end
                        CH_FF: begin
                            foreach (cells[i]) cells[i] = BLANK_CELL;
                            row = '0;
                            col = '0;
                            n_clears++;
                        end
                        CH_CR: begin
                            col = '0;
                        end
                        default: ;
                    endcase
                end
            end else begin
                n_reads++;
                if (idx < NCELLS) r.data = cells[idx];
            end
            r.row = row;
            r.col = col;
            r.pos = 11'(int'(row) * COLS + int'(col));
            pending_cursors.push_back(r);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            $display("[%0t] MISMATCH result %0d: %s got %0h, expected %0h",
                     $realtime, n_checked, what, got, want);
            n_errors++;
        endtask

        task check_result(logic [4:0] row_q, logic [6:0] col_q, logic [10:0] pos_q,
                          logic [15:0] cell_q);
            t_cursor_result want;
            if (pending_cursors.size() == 0) begin
                report_mismatch("unexpected result, nothing pending", 16'(pos_q), '0);
                return;
            end
            want = pending_cursors.pop_front();
            if (row_q !== want.row)   report_mismatch("cursor_row", 16'(row_q), 16'(want.row));
            if (col_q !== want.col)   report_mismatch("cursor_col", 16'(col_q), 16'(want.col));
            if (pos_q !== want.pos)   report_mismatch("cursor_pos", 16'(pos_q), 16'(want.pos));
            if (cell_q !== want.data) report_mismatch("cell_data", cell_q, want.data);
            n_checked++;
        endtask
    endclass

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // Input channel, result channel and attribute port; the bench drives start known
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_cmd = CMD_CHAR;
    logic [7:0]  i_char_code = '0;
    logic [10:0] i_cell_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic [10:0] o_cursor_pos;
    logic [15:0] o_cell_data;
    logic        i_attr_we = 1'b0;
    logic [7:0]  i_attr_data = '0;

    // Idle percent (sender per item, receiver per cycle); long receiver hold-off
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic pressure_go = 1'b0;
    logic rx_hold = 1'b0;

    t_console_shadow sb;

    text_console_cursor_engine_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_data  (o_cell_data),
        .i_attr_we    (i_attr_we),
        .i_attr_data  (i_attr_data)
    );

    // Receive side: check the result taken at this edge (pre-edge values),
    // then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            sb.check_result(o_cursor_row, o_cursor_col, o_cursor_pos, o_cell_data);
        i_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end

    // Hold the result channel off for a long stretch once asked, so the
    // block fills up and pushes back on its input.
    initial begin : rx_long_hold
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Give up on a hang; scrolls and clears each walk the whole store
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[%0t] timeout, %0d results still pending",
                 $realtime, sb.pending_cursors.size());
        $display("testbench NOT OK");
        $finish;
    end

    // Offer one item, maybe after an idle gap; return at the edge that took it.
    // The valid stays high into the next call unless that call idles first.
    task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [10:0] idx);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_char_code  <= ch;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(cmd, ch, idx);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending_cursors.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        i_attr_we   <= 1'b1;
        i_attr_data <= value;
        @(posedge i_clk);
        i_attr_we <= 1'b0;
        sb.attr = value;
    endtask

    function automatic logic [7:0] any_printable();
        return 8'($urandom_range(CH_PR_LO, CH_PR_HI));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Bytes with no effect: below backspace, vertical tab, 14..31, 127 and up
    function automatic logic [7:0] any_ignored();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(0, 7));
            1:       return 8'd11;
            2:       return 8'($urandom_range(14, 31));
            default: return 8'($urandom_range(127, 255));
        endcase
    endfunction

    // Read index: some on the cursor row to see fresh text, most anywhere,
    // a few past the end of the store
    function automatic logic [10:0] any_cell();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return 11'(int'(sb.row) * COLS + $urandom_range(0, COLS - 1));
        if (pick < 95) return 11'($urandom_range(0, NCELLS - 1));
        return 11'($urandom_range(NCELLS, 2047));
    endfunction

    task automatic send_one_random();
        int pick;
        logic [10:0] junk;
        pick = $urandom_range(99);
        junk = 11'($urandom_range(0, 2047));
        if (pick < 50)      send_item(CMD_CHAR, any_printable(), junk);
        else if (pick < 58) send_item(CMD_CHAR, CH_LF, junk);
        else if (pick < 66) send_item(CMD_CHAR, CH_TAB, junk);
        else if (pick < 71) send_item(CMD_CHAR, CH_BS, junk);
        else if (pick < 75) send_item(CMD_CHAR, CH_CR, junk);
        else if (pick < 76) send_item(CMD_CHAR, CH_FF, junk);
        else if (pick < 82) send_item(CMD_CHAR, any_ignored(), junk);
        else                send_item(CMD_READ, any_byte(), any_cell());
    endtask

    // Random traffic: mostly single items, plus runs of line feeds that push
    // the cursor to the bottom row and long text that wraps the column
    task automatic run_random(input int count);
        int sent;
        int pick;
        int run_len;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                run_len = $urandom_range(5, 25);
                repeat (run_len) send_item(CMD_CHAR, CH_LF, 11'($urandom_range(0, 2047)));
                sent += run_len;
            end else if (pick < 3) begin
                run_len = $urandom_range(60, 100);
                repeat (run_len) send_item(CMD_CHAR, any_printable(), 11'($urandom_range(0, 2047)));
                sent += run_len;
            end else begin
                send_one_random();
                sent++;
            end
        end
    endtask

    // Field extremes, every control byte, ignored bytes, backspace at column
    // zero, reads at both ends of the store and past it, and a form feed
    task automatic run_directed();
        send_item(CMD_CHAR, 8'h41, '0);
        send_item(CMD_CHAR, CH_PR_LO, '0);
        send_item(CMD_CHAR, CH_PR_HI, '0);
        send_item(CMD_CHAR, 8'd31, '0);
        send_item(CMD_CHAR, 8'd127, '0);
        send_item(CMD_CHAR, 8'd255, '0);
        send_item(CMD_CHAR, 8'd0, 11'h7FF);
        repeat (4) send_item(CMD_CHAR, CH_BS, '0);
        send_item(CMD_CHAR, CH_TAB, '0);
        send_item(CMD_CHAR, CH_TAB, '0);
        send_item(CMD_CHAR, CH_CR, '0);
        send_item(CMD_CHAR, CH_LF, '0);
        send_item(CMD_READ, 8'hFF, 11'd0);
        send_item(CMD_READ, '0, 11'd1);
        send_item(CMD_READ, '0, 11'd2);
        send_item(CMD_READ, '0, 11'(NCELLS - 1));
        send_item(CMD_READ, '0, 11'(NCELLS));
        send_item(CMD_READ, '0, 11'h7FF);
        send_item(CMD_CHAR, CH_FF, '0);
        send_item(CMD_READ, '0, 11'd0);
        send_item(CMD_READ, '0, 11'd1);
    endtask

    initial begin : sequencer
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items run with the attribute left at its reset value
        run_directed();
        wait_drained();

        // Sender idles a little, receiver a lot; blank attribute
        write_attribute(8'h00);
        tx_idle_pct <= 13;
        rx_idle_pct <= 78;
        run_random(185);
        wait_drained();

        // Swap the idling sides; full attribute
        write_attribute(8'hFF);
        tx_idle_pct <= 78;
        rx_idle_pct <= 13;
        run_random(185);
        wait_drained();

        // No idling, but one long receiver hold-off while items keep coming
        write_attribute(8'($urandom_range(1, 254)));
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        pressure_go <= 1'b1;
        run_random(180);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d reads, %0d scrolls, %0d clears, %0d column wraps.",
                 sb.n_items, sb.n_reads, sb.n_scrolls, sb.n_clears, sb.n_wraps);
        $display("Checked %0d results, %0d mismatches.", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_cursors.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/tcce_pkg.sv
design/tcce_ram.sv
design/text_console_cursor_engine_top.sv
bench/testbench.sv
